@@ src/upc_pkg.sv @@
`timescale 1ns / 1ps

package upc_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CASE_GAP = 8'd32;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  typedef enum logic [1:0] {
    MODE_PREFIX,
    MODE_HOST,
    MODE_PATH,
    MODE_DROP
  } mode_t;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_PCT,
    ESC_DIGIT
  } esc_t;

  // One queue entry: a run of buffered prefix bytes followed by up to three
  // further characters. An entry with nothing to emit is the empty end marker.
  typedef struct packed {
    logic [6:0][7:0] pfx;
    logic [2:0]      flush;
    logic [2:0][7:0] ext;
    logic [1:0]      ext_n;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [7:0] pat_plain(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h68;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h70;
      3'd4:    c = 8'h3a;
      3'd5:    c = 8'h2f;
      3'd6:    c = 8'h2f;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pat_secure(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h68;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h70;
      3'd4:    c = 8'h73;
      3'd5:    c = 8'h3a;
      3'd6:    c = 8'h2f;
      default: c = 8'h2f;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + CASE_GAP : b;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b[3:0];
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = 4'(b - 8'h61) + HEX_TEN;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = 4'(b - 8'h41) + HEX_TEN;
    end
    return v;
  endfunction

endpackage

@@ src/upc_front.sv @@
`timescale 1ns / 1ps

module upc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_acc,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          push,
  output upc_pkg::cmd_t cmd
);

  upc_pkg::mode_t  mode_r, mode_nxt;
  upc_pkg::esc_t   esc_r, esc_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic            sec_r, sec_nxt;
  logic [7:0]      dig_r, dig_nxt;
  logic [7:0][7:0] buf_r, buf_nxt;

  logic [2:0]      flush;
  logic [2:0][7:0] ext;
  logic [1:0]      ext_n;
  logic [7:0]      lb;
  logic [7:0]      ex;
  logic [3:0]      cnt4;
  logic [7:0]      dv;
  logic            match;
  logic            path_b;
  logic            run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= upc_pkg::MODE_PREFIX;
      esc_r  <= upc_pkg::ESC_IDLE;
      cnt_r  <= 3'd0;
      sec_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      cnt_r  <= cnt_nxt;
      sec_r  <= sec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    dig_r <= dig_nxt;
  end

  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    cnt_nxt  = cnt_r;
    sec_nxt  = sec_r;
    dig_nxt  = dig_r;
    buf_nxt  = buf_r;
    flush    = 3'd0;
    ext      = '0;
    ext_n    = 2'd0;
    lb       = upc_pkg::to_lower(in_byte);
    ex       = 8'h00;
    cnt4     = 4'd0;
    dv       = 8'h00;
    match    = 1'b0;
    path_b   = 1'b0;
    run      = 1'b1;
    if (in_acc) begin
      unique case (mode_r)
        upc_pkg::MODE_PREFIX: begin
          if (cnt_r == 3'd4 && !sec_r && lb == upc_pkg::CH_S) begin
            sec_nxt = 1'b1;
            match   = 1'b1;
          end else begin
            ex    = sec_r ? upc_pkg::pat_secure(cnt_r) : upc_pkg::pat_plain(cnt_r);
            match = (ex != 8'h00) && (lb == ex);
          end
          if (match) begin
            buf_nxt[cnt_r] = in_byte;
            cnt4 = {1'b0, cnt_r} + 4'd1;
            if (cnt4 == (sec_nxt ? 4'd8 : 4'd7)) begin
              mode_nxt = upc_pkg::MODE_HOST;
              cnt_nxt  = 3'd0;
            end else begin
              cnt_nxt = cnt4[2:0];
            end
          end else begin
            // Mismatch: replay what was buffered, then treat the byte as path.
            flush    = cnt_r;
            cnt_nxt  = 3'd0;
            sec_nxt  = 1'b0;
            mode_nxt = upc_pkg::MODE_PATH;
            path_b   = 1'b1;
          end
        end
        upc_pkg::MODE_HOST: begin
          if (in_byte == upc_pkg::CH_SLASH) begin
            mode_nxt   = upc_pkg::MODE_PATH;
            ext[ext_n] = upc_pkg::CH_SLASH;
            ext_n      = ext_n + 2'd1;
          end else if (in_byte == upc_pkg::CH_NUL || in_byte == upc_pkg::CH_QMARK) begin
            mode_nxt   = upc_pkg::MODE_DROP;
            ext[ext_n] = upc_pkg::CH_SLASH;
            ext_n      = ext_n + 2'd1;
          end
        end
        upc_pkg::MODE_PATH: begin
          path_b = 1'b1;
        end
        upc_pkg::MODE_DROP: begin
        end
        default: begin
        end
      endcase

      if (path_b) begin
        unique case (esc_r)
          upc_pkg::ESC_PCT: begin
            if (upc_pkg::is_hex(in_byte)) begin
              dig_nxt = in_byte;
              esc_nxt = upc_pkg::ESC_DIGIT;
              run     = 1'b0;
            end else begin
              ext[ext_n] = upc_pkg::CH_PCT;
              ext_n      = ext_n + 2'd1;
              esc_nxt    = upc_pkg::ESC_IDLE;
            end
          end
          upc_pkg::ESC_DIGIT: begin
            if (upc_pkg::is_hex(in_byte)) begin
              dv      = {upc_pkg::hex_value(dig_r), upc_pkg::hex_value(in_byte)};
              esc_nxt = upc_pkg::ESC_IDLE;
              run     = 1'b0;
              if (dv == 8'h00) begin
                mode_nxt = upc_pkg::MODE_DROP;
              end else begin
                ext[ext_n] = dv;
                ext_n      = ext_n + 2'd1;
              end
            end else begin
              // Broken escape: the percent sign and the held digit go out as text.
              ext[ext_n] = upc_pkg::CH_PCT;
              ext_n      = ext_n + 2'd1;
              ext[ext_n] = dig_r;
              ext_n      = ext_n + 2'd1;
              esc_nxt    = upc_pkg::ESC_IDLE;
            end
          end
          default: begin
            esc_nxt = upc_pkg::ESC_IDLE;
          end
        endcase
        if (run) begin
          if (in_byte == upc_pkg::CH_NUL || in_byte == upc_pkg::CH_QMARK) begin
            mode_nxt = upc_pkg::MODE_DROP;
          end else if (in_byte == upc_pkg::CH_PCT) begin
            esc_nxt = upc_pkg::ESC_PCT;
          end else begin
            ext[ext_n] = in_byte;
            ext_n      = ext_n + 2'd1;
          end
        end
      end

      if (in_last) begin
        unique case (mode_nxt)
          upc_pkg::MODE_PREFIX: begin
            flush = cnt_nxt;
          end
          upc_pkg::MODE_HOST: begin
            ext[ext_n] = upc_pkg::CH_SLASH;
            ext_n      = ext_n + 2'd1;
          end
          upc_pkg::MODE_PATH: begin
            if (esc_nxt == upc_pkg::ESC_PCT) begin
              ext[ext_n] = upc_pkg::CH_PCT;
              ext_n      = ext_n + 2'd1;
            end else if (esc_nxt == upc_pkg::ESC_DIGIT) begin
              ext[ext_n] = upc_pkg::CH_PCT;
              ext_n      = ext_n + 2'd1;
              ext[ext_n] = dig_nxt;
              ext_n      = ext_n + 2'd1;
            end
          end
          default: begin
          end
        endcase
        mode_nxt = upc_pkg::MODE_PREFIX;
        esc_nxt  = upc_pkg::ESC_IDLE;
        cnt_nxt  = 3'd0;
        sec_nxt  = 1'b0;
      end
    end
  end

  assign cmd.pfx   = buf_nxt[6:0];
  assign cmd.flush = flush;
  assign cmd.ext   = ext;
  assign cmd.ext_n = ext_n;
  assign cmd.last  = in_last;
  assign push      = in_acc && (flush != 3'd0 || ext_n != 2'd0 || in_last);

endmodule

@@ src/upc_queue.sv @@
`timescale 1ns / 1ps

module upc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  upc_pkg::cmd_t    din,
  input  logic             pop,
  output upc_pkg::cmd_t    dout,
  output upc_pkg::q_stat_t stat
);

  upc_pkg::cmd_t          mem [upc_pkg::QDEPTH];
  logic [upc_pkg::QAW-1:0] wp_r, rp_r;
  logic [upc_pkg::QAW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + (upc_pkg::QAW)'(1'b1);
      end
      if (pop) begin
        rp_r <= rp_r + (upc_pkg::QAW)'(1'b1);
      end
      cnt_r <= cnt_r + (upc_pkg::QAW+1)'(push) - (upc_pkg::QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= din;
    end
  end

  assign dout       = mem[rp_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (upc_pkg::QAW+1)'(upc_pkg::QDEPTH));

endmodule

@@ src/upc_back.sv @@
`timescale 1ns / 1ps

module upc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  upc_pkg::cmd_t    head,
  input  upc_pkg::q_stat_t stat,
  output logic             pop,
  output logic             out_word_valid,
  input  logic             out_word_ready,
  output logic [7:0]       out_byte,
  output logic             out_valid,
  output logic             out_last
);

  logic [3:0] pos_r;
  logic       ovld_r;
  logic [7:0] byte_r;
  logic       chr_r;
  logic       last_r;

  logic [3:0] total;
  logic [3:0] off;
  logic       fin;
  logic       ld;
  logic [7:0] sel;

  assign total = {1'b0, head.flush} + {2'b00, head.ext_n};
  assign off   = pos_r - {1'b0, head.flush};
  assign fin   = (total == 4'd0) || (pos_r == total - 4'd1);
  assign ld    = !stat.empty && (!ovld_r || out_word_ready);
  assign pop   = ld && fin;

  always_comb begin
    if (pos_r < {1'b0, head.flush}) begin
      sel = head.pfx[pos_r[2:0]];
    end else begin
      sel = head.ext[off[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
      pos_r  <= 4'd0;
    end else if (ld) begin
      ovld_r <= 1'b1;
      pos_r  <= fin ? 4'd0 : pos_r + 4'd1;
    end else if (out_word_ready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      if (total == 4'd0) begin
        // Nothing came out of this URI: send the empty end marker.
        byte_r <= 8'h00;
        chr_r  <= 1'b0;
        last_r <= 1'b1;
      end else begin
        byte_r <= sel;
        chr_r  <= 1'b1;
        last_r <= head.last && fin;
      end
    end
  end

  assign out_word_valid = ovld_r;
  assign out_byte       = byte_r;
  assign out_valid      = chr_r;
  assign out_last       = last_r;

endmodule

@@ src/uri_path_canonicalizer.sv @@
`timescale 1ns / 1ps

// Channel | Ports                                   | Handshake
// input   | in_byte[7:0], in_last                   | in_word_valid / in_word_ready
// output  | out_byte[7:0], out_valid, out_last      | out_word_valid / out_word_ready
//
// One input word is taken per cycle while the four-entry command queue has room.
// The output side sends one word per cycle while out_word_ready is high; an input word
// that yields k output words (up to eight, e.g. a replayed scheme prefix) holds the
// output stage until all k are sent. Input bytes that yield nothing take no queue slot.
// rst_n is synchronous and active low; no clearing pass follows it.
// Either side may stall; the queue between classifier and emitter absorbs it.

module uri_path_canonicalizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_word_valid,
  output logic       in_word_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_word_valid,
  input  logic       out_word_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  upc_pkg::cmd_t    q_din;
  upc_pkg::cmd_t    q_dout;
  upc_pkg::q_stat_t q_stat;
  logic             q_push;
  logic             q_pop;
  logic             in_acc;

  assign in_word_ready = !q_stat.full;
  assign in_acc        = in_word_valid && in_word_ready;

  upc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (q_push),
    .cmd     (q_din)
  );

  upc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  upc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_dout),
    .stat           (q_stat),
    .pop            (q_pop),
    .out_word_valid (out_word_valid),
    .out_word_ready (out_word_ready),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_last       (out_last)
  );

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_word_valid && !out_valid |-> out_last && out_byte == 8'h00)
    else $error("empty end marker without last flag or with nonzero byte");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("command queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command queue pushed while full");

endmodule
